@@ sv/mdd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mdd_pkg;

   // width of the drawdown fraction (q0.16)
   localparam int FRAC_BITS = 16;
   localparam logic [FRAC_BITS-1:0] FRACTION_MAX = '1;

   // one quotient bit per divide step
   localparam int DIV_COUNT_BITS = 4;
   localparam logic [DIV_COUNT_BITS-1:0] DIV_LAST = DIV_COUNT_BITS'(FRAC_BITS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_OUTPUT = 4'b1000
   } mdd_state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic div_last;
      logic load_out;
   } mdd_cmd_type;

   typedef struct packed {
      logic need_div;
   } mdd_status_type;

endpackage

`default_nettype wire

@@ sv/mdd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdd_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  mdd_pkg::mdd_status_type status,
   output mdd_pkg::mdd_cmd_type    cmd
);

   mdd_pkg::mdd_state_type state_ff, state_in;
   logic [mdd_pkg::DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         mdd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = mdd_pkg::ST_UPDATE;
            end
         end
         mdd_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            count_in   = '0;
            if (status.need_div) begin
               state_in = mdd_pkg::ST_DIVIDE;
            end else begin
               state_in = mdd_pkg::ST_OUTPUT;
            end
         end
         mdd_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == mdd_pkg::DIV_LAST) begin
               cmd.div_last = 1'b1;
               state_in     = mdd_pkg::ST_OUTPUT;
            end
         end
         mdd_pkg::ST_OUTPUT: begin
            // result slot free, or being emptied this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdd_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/mdd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdd_datapath #(
   parameter int VALUE_BITS = 32,
   parameter int INDEX_BITS = 20
) (
   input  wire                              clock,
   input  wire                              reset,
   input  mdd_pkg::mdd_cmd_type              cmd,
   output mdd_pkg::mdd_status_type           status,
   input  wire [VALUE_BITS-1:0]             value_sample,
   input  wire                              start_series,
   output logic [mdd_pkg::FRAC_BITS-1:0]    drawdown_fraction,
   output logic [VALUE_BITS-1:0]            drawdown_amount,
   output logic [INDEX_BITS:0]              drawdown_length,
   output logic [INDEX_BITS-1:0]            peak_position,
   output logic [INDEX_BITS-1:0]            trough_position
);

   // captured request
   logic [VALUE_BITS-1:0] sample_ff;
   logic                  start_ff;

   // tracking state
   logic [VALUE_BITS-1:0] peak_ff, trough_ff, best_drop_ff;
   logic [INDEX_BITS-1:0] peak_idx_ff, position_ff, best_peak_ff, best_trough_ff;
   logic [mdd_pkg::FRAC_BITS-1:0] best_frac_ff;

   // divider
   logic [VALUE_BITS-1:0]         rem_ff, rem_in, gap;
   logic [mdd_pkg::FRAC_BITS-1:0] quot_ff, quot_in;

   // result register
   logic [mdd_pkg::FRAC_BITS-1:0] out_frac_ff;
   logic [VALUE_BITS-1:0]         out_amount_ff;
   logic [INDEX_BITS:0]           out_length_ff;
   logic [INDEX_BITS-1:0]         out_peak_ff, out_trough_ff;

   logic [VALUE_BITS-1:0] drop;
   logic                  rise, new_best;
   logic [INDEX_BITS-1:0] span;

   assign drop     = peak_ff - sample_ff;
   assign rise     = sample_ff > peak_ff;
   assign new_best = !start_ff && !rise && (sample_ff < trough_ff) && (drop > best_drop_ff);
   // a trough of zero means the drop equals the peak: saturated, no divide
   assign status.need_div = new_best && (sample_ff != '0);

   assign gap = peak_ff - rem_ff;
   always_comb begin
      if (rem_ff >= gap) begin
         rem_in  = rem_ff - gap;
         quot_in = {quot_ff[mdd_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
         rem_in  = {rem_ff[VALUE_BITS-2:0], 1'b0};
         quot_in = {quot_ff[mdd_pkg::FRAC_BITS-2:0], 1'b0};
      end
   end

   assign span = best_trough_ff - best_peak_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= value_sample;
         start_ff  <= start_series;
      end
      if (cmd.update) begin
         rem_ff  <= drop;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.load_out) begin
         out_frac_ff   <= best_frac_ff;
         out_amount_ff <= best_drop_ff;
         out_length_ff <= {1'b0, span} + 1'b1;
         out_peak_ff   <= best_peak_ff;
         out_trough_ff <= best_trough_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff        <= '0;
         trough_ff      <= '0;
         peak_idx_ff    <= '0;
         position_ff    <= '0;
         best_drop_ff   <= '0;
         best_peak_ff   <= '0;
         best_trough_ff <= '0;
         best_frac_ff   <= '0;
      end else if (cmd.update) begin
         if (start_ff) begin
            peak_ff        <= sample_ff;
            trough_ff      <= sample_ff;
            peak_idx_ff    <= '0;
            position_ff    <= INDEX_BITS'(1);
            best_drop_ff   <= '0;
            best_peak_ff   <= '0;
            best_trough_ff <= '0;
            best_frac_ff   <= '0;
         end else begin
            position_ff <= position_ff + 1'b1;
            if (rise) begin
               peak_ff     <= sample_ff;
               trough_ff   <= sample_ff;
               peak_idx_ff <= position_ff;
            end else if (new_best) begin
               trough_ff      <= sample_ff;
               best_drop_ff   <= drop;
               best_peak_ff   <= peak_idx_ff;
               best_trough_ff <= position_ff;
               if (sample_ff == '0) begin
                  best_frac_ff <= mdd_pkg::FRACTION_MAX;
               end
            end
         end
      end else if (cmd.div_last) begin
         best_frac_ff <= quot_in;
      end
   end

   assign drawdown_fraction = out_frac_ff;
   assign drawdown_amount   = out_amount_ff;
   assign drawdown_length   = out_length_ff;
   assign peak_position     = out_peak_ff;
   assign trough_position   = out_trough_ff;

endmodule

`default_nettype wire

@@ sv/max_drawdown_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// maximum drawdown tracker: each request carries one unsigned q16.16 portfolio
// value (req_tdata) and a series-start flag (req_tuser); each request gives
// exactly one response with the best peak-to-trough drop so far, that drop as a
// q0.16 fraction of its peak (saturating at all ones), its length and the
// sample positions of its peak and trough. one request is handled at a time:
// a request with no new best drawdown, or a new best whose trough is zero,
// goes from the update straight to the output load; any other new best passes
// through the radix-2 restoring divider, which retires one quotient bit per
// cycle. the load waits while an earlier response is still not taken. the
// controller is back in idle the cycle after the load. the response sits
// in its own register, so the next request is taken while a response waits.

module max_drawdown_tracker #(
   parameter int VALUE_BITS = 32,
   parameter int INDEX_BITS = 20
) (
   input  wire  clock,
   input  wire  reset,
   // request channel
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // value_sample
   input  wire  [((VALUE_BITS+7)/8)*8-1:0] req_tdata,
   // start_series
   input  wire  [0:0]                   req_tuser,
   // response channel
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // drawdown_fraction, drawdown_amount, drawdown_length, peak_position,
   // trough_position, zero padded to whole bytes
   output logic [((mdd_pkg::FRAC_BITS+VALUE_BITS+3*INDEX_BITS+1+7)/8)*8-1:0] rsp_tdata
);

   localparam int RSP_FIELD_BITS = mdd_pkg::FRAC_BITS + VALUE_BITS + 3*INDEX_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   mdd_pkg::mdd_cmd_type    cmd;
   mdd_pkg::mdd_status_type status;

   logic [mdd_pkg::FRAC_BITS-1:0] drawdown_fraction;
   logic [VALUE_BITS-1:0]         drawdown_amount;
   logic [INDEX_BITS:0]           drawdown_length;
   logic [INDEX_BITS-1:0]         peak_position;
   logic [INDEX_BITS-1:0]         trough_position;

   // sequencer: accept, update, divide, load response
   mdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // tracking registers, divider and response register
   mdd_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .value_sample      (req_tdata[VALUE_BITS-1:0]),
      .start_series      (req_tuser[0]),
      .drawdown_fraction (drawdown_fraction),
      .drawdown_amount   (drawdown_amount),
      .drawdown_length   (drawdown_length),
      .peak_position     (peak_position),
      .trough_position   (trough_position)
   );

   // first field in the lowest bits, zero fill above
   assign rsp_tdata = RSP_DATA_BITS'({trough_position, peak_position, drawdown_length,
                                      drawdown_amount, drawdown_fraction});

endmodule

`default_nettype wire

@@ tb/max_drawdown_tracker_tb.sv @@
`timescale 1ns / 1ps

module max_drawdown_tracker_tb;

   localparam int VALUE_BITS = 32;
   localparam int INDEX_BITS = 20;
   localparam int LENGTH_BITS = INDEX_BITS + 1;
   // response payload before padding to whole bytes
   localparam int RSP_FIELD_BITS = mdd_pkg::FRAC_BITS + VALUE_BITS + LENGTH_BITS
                                   + 2 * INDEX_BITS;
   localparam int RSP_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // enough random requests to cover many series
   localparam int RANDOM_REQUESTS = 1250;
   // settle time after the last response, longer than one full divide request
   localparam int DRAIN_CYCLES = 40;

   // one response as packed on rsp_tdata, highest field first
   typedef struct packed {
      logic [INDEX_BITS-1:0]         trough_position;
      logic [INDEX_BITS-1:0]         peak_position;
      logic [LENGTH_BITS-1:0]        drawdown_length;
      logic [VALUE_BITS-1:0]         drawdown_amount;
      logic [mdd_pkg::FRAC_BITS-1:0] drawdown_fraction;
   } drawdown_result_type;

   // tracks the drawdown state, predicts each response and checks it
   class drawdown_scoreboard;
      drawdown_result_type expected_q[$];
      int errors;
      logic [VALUE_BITS-1:0] peak_value;
      logic [VALUE_BITS-1:0] trough_value;
      logic [VALUE_BITS-1:0] best_drop;
      logic [INDEX_BITS-1:0] run_peak_pos;
      logic [INDEX_BITS-1:0] next_index;
      logic [INDEX_BITS-1:0] best_peak_pos;
      logic [INDEX_BITS-1:0] best_trough_pos;
      logic [mdd_pkg::FRAC_BITS-1:0] best_fraction;

      function new();
         errors = 0;
         peak_value = '0;
         trough_value = '0;
         best_drop = '0;
         run_peak_pos = '0;
         next_index = '0;
         best_peak_pos = '0;
         best_trough_pos = '0;
         best_fraction = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // restoring division, one quotient bit per step, truncated
      function logic [mdd_pkg::FRAC_BITS-1:0] drop_fraction(logic [VALUE_BITS-1:0] drop,
                                                            logic [VALUE_BITS-1:0] peak);
         logic [VALUE_BITS-1:0] rem;
         logic [VALUE_BITS-1:0] gap;
         logic [mdd_pkg::FRAC_BITS-1:0] quot;
         if (peak == '0) return '0;
         if (drop >= peak) return mdd_pkg::FRACTION_MAX;
         rem = drop;
         quot = '0;
         for (int k = 0; k < mdd_pkg::FRAC_BITS; k++) begin
            // rem < peak, so doubling is compared against the gap to peak
            gap = peak - rem;
            quot = quot << 1;
            if (rem >= gap) begin
               rem = rem - gap;
               quot[0] = 1'b1;
            end else begin
               rem = rem + rem;
            end
         end
         return quot;
      endfunction

      // update the tracking state with an accepted request
      function void note_request(logic [VALUE_BITS-1:0] value, logic start);
         drawdown_result_type want;
         logic [INDEX_BITS-1:0] span;
         if (start) begin
            peak_value = value;
            trough_value = value;
            run_peak_pos = '0;
            best_drop = '0;
            best_peak_pos = '0;
            best_trough_pos = '0;
            best_fraction = '0;
            next_index = INDEX_BITS'(1);
         end else begin
            if (value > peak_value) begin
               peak_value = value;
               trough_value = value;
               run_peak_pos = next_index;
            end else if (value < trough_value && (peak_value - value) > best_drop) begin
               trough_value = value;
               best_drop = peak_value - value;
               best_peak_pos = run_peak_pos;
               best_trough_pos = next_index;
               best_fraction = drop_fraction(best_drop, peak_value);
            end
            next_index = next_index + 1'b1;
         end
         span = best_trough_pos - best_peak_pos;
         want.drawdown_fraction = best_fraction;
         want.drawdown_amount = best_drop;
         want.drawdown_length = LENGTH_BITS'(span) + 1'b1;
         want.peak_position = best_peak_pos;
         want.trough_position = best_trough_pos;
         expected_q.insert(expected_q.size(), want);
      endfunction

      task report(string what, logic [VALUE_BITS-1:0] got, logic [VALUE_BITS-1:0] want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_response(logic [RSP_BITS-1:0] data);
         drawdown_result_type got;
         drawdown_result_type want;
         got = drawdown_result_type'(data[RSP_FIELD_BITS-1:0]);
         if (expected_q.size() == 0) begin
            report("response with no request waiting", '0, '0);
         end else begin
            want = expected_q.pop_front();
            if (got.drawdown_fraction !== want.drawdown_fraction)
               report("drawdown_fraction", got.drawdown_fraction, want.drawdown_fraction);
            if (got.drawdown_amount !== want.drawdown_amount)
               report("drawdown_amount", got.drawdown_amount, want.drawdown_amount);
            if (got.drawdown_length !== want.drawdown_length)
               report("drawdown_length", got.drawdown_length, want.drawdown_length);
            if (got.peak_position !== want.peak_position)
               report("peak_position", got.peak_position, want.peak_position);
            if (got.trough_position !== want.trough_position)
               report("trough_position", got.trough_position, want.trough_position);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // value_sample
   logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata = '0;
   // start_series
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // drawdown_fraction, drawdown_amount, drawdown_length, peak_position,
   // trough_position, zero padding
   logic [RSP_BITS-1:0] rsp_tdata;

   // when set, neither side idles, so requests go back to back
   bit calm = 1'b0;
   int sent = 0;
   drawdown_scoreboard tracker_sb;

   max_drawdown_tracker #(
      .VALUE_BITS(VALUE_BITS),
      .INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // drive one request, idling first for a random gap unless calm; valid stays high across back-to-back requests
   task send_sample(logic [VALUE_BITS-1:0] value, logic start);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      tracker_sb.note_request(value, start);
      sent++;
   endtask

   // hold the sender until every predicted response has come back
   task drain_responses();
      req_tvalid <= 1'b0;
      while (tracker_sb.pending() != 0) @(posedge clock);
   endtask

   // one series: a random walk over a random base, or noise with random starts
   task send_series();
      logic [63:0] level;
      logic [63:0] delta;
      int len;
      bit noise;
      len = $urandom_range(2, 40);
      noise = ($urandom_range(0, 7) == 0);
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
         0: level = $urandom_range(0, 1000);
         1: level = 64'hFFFF_FFFF - $urandom_range(0, 1000);
         default: level = $urandom;
      endcase
      for (int i = 0; i < len; i++) begin
         if (noise) begin
            send_sample($urandom, $urandom_range(0, 1));
         end else begin
            case ($urandom_range(0, 3))
               0: delta = $urandom_range(0, 255);
               1: delta = $urandom & 32'h000F_FFFF;
               2: delta = $urandom >> $urandom_range(0, 31);
               default: delta = $urandom;
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2, 3: level = (level + delta > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF
                                                                   : level + delta;
               4, 5, 6, 7: level = (delta > level) ? 64'd0 : level - delta;
               8: level = level;   // repeat value, equal to peak or trough
               default: level = ($urandom_range(0, 1) == 0) ? 64'd0 : $urandom;
            endcase
            // occasionally a stray series start in the middle of a walk
            send_sample(level[VALUE_BITS-1:0],
                        (i == 0) || ($urandom_range(0, 63) == 0));
         end
      end
   endtask

   // response side: random stall per response, then check on handshake
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker_sb.check_response(rsp_tdata);
      end
   end

   initial begin
      int series_count;
      series_count = 0;
      tracker_sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no series start after reset: compare against the zero reset state
      send_sample(32'h0000_0000, 1'b0);   // equal to the zero peak
      send_sample(32'h0001_0000, 1'b0);   // new peak
      send_sample(32'h0000_8000, 1'b0);   // half drop
      send_sample(32'h0000_8000, 1'b0);   // equal to trough
      send_sample(32'h0000_4000, 1'b0);   // deeper drop
      send_sample(32'h0002_0000, 1'b0);   // higher peak
      send_sample(32'h0001_FFFF, 1'b0);   // drop too small to beat best
      // full-scale series, falling to zero saturates the fraction
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      // series starting from zero
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      // mixed patterns, trough between and below
      send_sample(32'h1234_5678, 1'b1);
      send_sample(32'hEDCB_A987, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      // back-to-back series starts
      send_sample(32'h0000_0001, 1'b1);
      send_sample(32'hAAAA_AAAA, 1'b1);
      send_sample(32'h5555_5555, 1'b0);
      drain_responses();

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         send_series();
         series_count++;
         if (series_count == 10 || $urandom_range(0, 19) == 0) drain_responses();
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (tracker_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker_sb.errors == 0 && tracker_sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mdd_pkg.sv
sv/mdd_ctrl.sv
sv/mdd_datapath.sv
sv/max_drawdown_tracker.sv
tb/max_drawdown_tracker_tb.sv
